@@ design/skvt_pkg.sv @@
// Shared types and constants for the small key/value table.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package skvt_pkg;

    // Table geometry
    localparam int TABLE_SLOTS = 16;
    localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int LIM_W       = $clog2(TABLE_SLOTS + 1);

    // Field widths
    localparam int HALF_W  = 32;
    localparam int KEY_W   = 2 * HALF_W;
    localparam int VAL_W   = 2 * HALF_W;
    localparam int ENTRY_W = KEY_W + VAL_W;
    localparam int OP_W    = 2;
    localparam int CFG_W   = 5;
    localparam int CNT_W   = 5;

    // Reset value of entries_in_use
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Operation codes (code 3 does nothing)
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RUN,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture the input transaction, restart scan
        logic scan;        // one step of the key scan
        logic add_commit;  // update or fill after the scan
        logic rm_commit;   // free the hit slot, start the run scan
        logic run_step;    // advance the run scan
        logic move_rd;     // read the last entry of the run
        logic move_wr;     // write it into the freed slot
        logic result;      // load the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            scan_end;
        logic            hit;
        logic            run_end;
        logic            run_move;
        logic            out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ design/skvt_if.sv @@
// Valid/ready channel interfaces for the key/value table.
// Depends on skvt_pkg for the field widths.
`default_nettype none

interface skvt_req_if;
    logic                                    valid;
    logic                                    ready;
    logic        [skvt_pkg::OP_W-1:0]        operation;
    logic signed [skvt_pkg::HALF_W-1:0]      key_first;
    logic signed [skvt_pkg::HALF_W-1:0]      key_second;
    logic signed [skvt_pkg::HALF_W-1:0]      value_first;
    logic signed [skvt_pkg::HALF_W-1:0]      value_second;

    modport source (
        output valid, operation, key_first, key_second, value_first, value_second,
        input  ready
    );
    modport sink (
        input  valid, operation, key_first, key_second, value_first, value_second,
        output ready
    );
endinterface

interface skvt_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    success;
    logic signed [skvt_pkg::HALF_W-1:0]      found_first;
    logic signed [skvt_pkg::HALF_W-1:0]      found_second;
    logic        [skvt_pkg::CNT_W-1:0]       stored_count;

    modport source (
        output valid, success, found_first, found_second, stored_count,
        input  ready
    );
    modport sink (
        input  valid, success, found_first, found_second, stored_count,
        output ready
    );
endinterface

`default_nettype wire

@@ design/skvt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module skvt_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/skvt_ctrl.sv @@
// Controller state machine for the key/value table.
// Depends on skvt_pkg; drives the datapath through t_cmd, watches t_sts.
`default_nettype none

module skvt_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire skvt_pkg::t_sts i_sts,
    output skvt_pkg::t_cmd      o_cmd
);

    skvt_pkg::t_state r_state;
    skvt_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skvt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            skvt_pkg::ST_IDLE: begin
                // nothing is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = skvt_pkg::ST_SCAN;
                end
            end
            skvt_pkg::ST_SCAN: begin
                if (!i_sts.scan_end) begin
                    o_cmd.scan = 1'b1;
                end else begin
                    case (i_sts.op)
                        skvt_pkg::OP_ADD: begin
                            o_cmd.add_commit = 1'b1;
                            n_state          = skvt_pkg::ST_DONE;
                        end
                        skvt_pkg::OP_REMOVE: begin
                            if (i_sts.hit) begin
                                o_cmd.rm_commit = 1'b1;
                                n_state         = skvt_pkg::ST_RUN;
                            end else begin
                                n_state = skvt_pkg::ST_DONE;
                            end
                        end
                        default: begin
                            n_state = skvt_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            skvt_pkg::ST_RUN: begin
                if (i_sts.run_end) begin
                    n_state = i_sts.run_move ? skvt_pkg::ST_MOVE_RD : skvt_pkg::ST_DONE;
                end else begin
                    o_cmd.run_step = 1'b1;
                end
            end
            skvt_pkg::ST_MOVE_RD: begin
                o_cmd.move_rd = 1'b1;
                n_state       = skvt_pkg::ST_MOVE_WR;
            end
            skvt_pkg::ST_MOVE_WR: begin
                o_cmd.move_wr = 1'b1;
                n_state       = skvt_pkg::ST_DONE;
            end
            skvt_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.result = 1'b1;
                    n_state      = skvt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = skvt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/skvt_dpath.sv @@
// Datapath of the key/value table: entry RAM, valid bits, scan counters,
// entry count, limit register and output register. Depends on skvt_pkg, skvt_ram.
`default_nettype none

module skvt_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [skvt_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire skvt_pkg::t_cmd                i_cmd,
    output skvt_pkg::t_sts                     o_sts,
    input  wire logic [skvt_pkg::OP_W-1:0]     i_op,
    input  wire logic [skvt_pkg::KEY_W-1:0]    i_key,
    input  wire logic [skvt_pkg::VAL_W-1:0]    i_val,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_out_ok,
    output logic      [skvt_pkg::VAL_W-1:0]    o_out_found,
    output logic      [skvt_pkg::CNT_W-1:0]    o_out_count
);

    // Control state
    logic [skvt_pkg::CFG_W-1:0]       r_entries;
    logic [skvt_pkg::TABLE_SLOTS-1:0] r_valid;
    logic [skvt_pkg::CNT_W-1:0]       r_total;
    logic [skvt_pkg::LIM_W-1:0]       r_idx;
    logic                             r_cmp_vld;
    logic [skvt_pkg::IDX_W-1:0]       r_cmp_idx;
    logic                             r_hit;
    logic                             r_free;
    logic [skvt_pkg::LIM_W-1:0]       r_run_idx;
    logic                             r_out_valid;

    // Payload
    logic [skvt_pkg::OP_W-1:0]        r_op;
    logic [skvt_pkg::KEY_W-1:0]       r_key;
    logic [skvt_pkg::VAL_W-1:0]       r_val;
    logic [skvt_pkg::IDX_W-1:0]       r_hit_idx;
    logic [skvt_pkg::IDX_W-1:0]       r_free_idx;
    logic [skvt_pkg::VAL_W-1:0]       r_found;
    logic                             r_out_ok;
    logic [skvt_pkg::VAL_W-1:0]       r_out_found;
    logic [skvt_pkg::CNT_W-1:0]       r_out_count;

    logic [skvt_pkg::LIM_W-1:0]       w_limit;
    logic [skvt_pkg::ENTRY_W-1:0]     w_rdata;
    logic [skvt_pkg::IDX_W-1:0]       w_raddr;
    logic [skvt_pkg::IDX_W-1:0]       w_waddr;
    logic [skvt_pkg::ENTRY_W-1:0]     w_wdata;
    logic                             w_we;
    logic                             w_match;
    logic                             w_ok;
    logic                             w_ret_val;
    logic [skvt_pkg::IDX_W-1:0]       w_run_pos;
    logic [skvt_pkg::IDX_W-1:0]       w_run_prev;
    logic [skvt_pkg::LIM_W-1:0]       w_hit_next;
    logic                             w_out_free;

    // Active slot count: saturate to the table size, zero counts as one
    always_comb begin
        if (int'(r_entries) > skvt_pkg::TABLE_SLOTS) begin
            w_limit = skvt_pkg::LIM_W'(skvt_pkg::TABLE_SLOTS);
        end else if (r_entries == '0) begin
            w_limit = skvt_pkg::LIM_W'(1);
        end else begin
            w_limit = skvt_pkg::LIM_W'(r_entries);
        end
    end

    assign w_run_pos  = r_run_idx[skvt_pkg::IDX_W-1:0];
    assign w_run_prev = w_run_pos - skvt_pkg::IDX_W'(1);
    assign w_hit_next = skvt_pkg::LIM_W'(r_hit_idx) + skvt_pkg::LIM_W'(1);

    // Key compare on the entry read in the previous scan step
    assign w_match = r_valid[r_cmp_idx] &&
                     (w_rdata[skvt_pkg::ENTRY_W-1:skvt_pkg::VAL_W] == r_key);

    // RAM port steering
    assign w_raddr = i_cmd.move_rd ? w_run_prev : r_idx[skvt_pkg::IDX_W-1:0];

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_hit_idx;
        w_wdata = {r_key, r_val};
        if (i_cmd.add_commit) begin
            w_we    = r_hit || r_free;
            w_waddr = r_hit ? r_hit_idx : r_free_idx;
        end else if (i_cmd.move_wr) begin
            w_we    = 1'b1;
            w_wdata = w_rdata;
        end
    end

    skvt_ram #(
        .WIDTH (skvt_pkg::ENTRY_W),
        .DEPTH (skvt_pkg::TABLE_SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Result of the finished operation
    always_comb begin
        case (r_op)
            skvt_pkg::OP_ADD: begin
                w_ok      = r_hit || r_free;
                w_ret_val = 1'b0;
            end
            skvt_pkg::OP_REMOVE: begin
                w_ok      = r_hit;
                w_ret_val = r_hit;
            end
            skvt_pkg::OP_LOOKUP: begin
                w_ok      = r_hit;
                w_ret_val = r_hit;
            end
            default: begin
                w_ok      = 1'b0;
                w_ret_val = 1'b0;
            end
        endcase
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries   <= skvt_pkg::CFG_RESET;
            r_valid     <= '0;
            r_total     <= '0;
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_cmp_idx   <= '0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_run_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_entries <= i_cfg_data;
            end

            // Start of a transaction
            if (i_cmd.load) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
                r_hit     <= 1'b0;
                r_free    <= 1'b0;
            end

            // Key scan: issue one read, compare the previous one
            if (i_cmd.scan) begin
                if (r_idx < w_limit) begin
                    r_idx     <= r_idx + skvt_pkg::LIM_W'(1);
                    r_cmp_vld <= 1'b1;
                    r_cmp_idx <= r_idx[skvt_pkg::IDX_W-1:0];
                end else begin
                    r_cmp_vld <= 1'b0;
                end
                if (r_cmp_vld) begin
                    if (w_match && !r_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (!r_valid[r_cmp_idx] && !r_free) begin
                        r_free <= 1'b1;
                    end
                end
            end

            // Fill a free slot when the key is new
            if (i_cmd.add_commit && !r_hit && r_free) begin
                r_valid[r_free_idx] <= 1'b1;
                r_total             <= r_total + skvt_pkg::CNT_W'(1);
            end

            // Free the hit slot and start looking for the end of the run
            if (i_cmd.rm_commit) begin
                r_valid[r_hit_idx] <= 1'b0;
                r_total            <= r_total - skvt_pkg::CNT_W'(1);
                r_run_idx          <= w_hit_next;
            end

            if (i_cmd.run_step) begin
                r_run_idx <= r_run_idx + skvt_pkg::LIM_W'(1);
            end

            // Last entry of the run fills the hole
            if (i_cmd.move_wr) begin
                r_valid[r_hit_idx]  <= 1'b1;
                r_valid[w_run_prev] <= 1'b0;
            end

            // Output register handshake
            if (i_cmd.result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_key <= i_key;
            r_val <= i_val;
        end
        if (i_cmd.scan && r_cmp_vld) begin
            if (w_match && !r_hit) begin
                r_hit_idx <= r_cmp_idx;
                r_found   <= w_rdata[skvt_pkg::VAL_W-1:0];
            end
            if (!r_valid[r_cmp_idx] && !r_free) begin
                r_free_idx <= r_cmp_idx;
            end
        end
        if (i_cmd.result) begin
            r_out_ok    <= w_ok;
            r_out_found <= w_ret_val ? r_found : '0;
            r_out_count <= r_total;
        end
    end

    // Status to the controller
    always_comb begin
        o_sts          = '0;
        o_sts.op       = r_op;
        o_sts.scan_end = r_hit || ((r_idx >= w_limit) && !r_cmp_vld);
        o_sts.hit      = r_hit;
        o_sts.run_end  = (r_run_idx >= w_limit) || !r_valid[w_run_pos];
        o_sts.run_move = (r_run_idx < w_limit) && (r_run_idx != w_hit_next);
        o_sts.out_free = w_out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_ok    = r_out_ok;
    assign o_out_found = r_out_found;
    assign o_out_count = r_out_count;

endmodule

`default_nettype wire

@@ design/small_key_value_table_top.sv @@
// Small key/value table; active slots = entries_in_use, capped at the table size.
// One transaction at a time: the key scan reads one slot per cycle from the entry RAM (a hit
// ends it early), then a remove walks the valid bits one slot per cycle and may move one entry.
// A new request is taken only once the previous result is in the output register, which can
// wait on o_rsp.ready. Reset (sync, active low) empties the table, limit = 16.
`default_nettype none

module small_key_value_table_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [skvt_pkg::CFG_W-1:0] i_cfg_data,
    skvt_req_if.sink                        i_req,
    skvt_rsp_if.source                      o_rsp
);

    skvt_pkg::t_cmd                 w_cmd;
    skvt_pkg::t_sts                 w_sts;
    logic                           w_in_ready;
    logic                           w_out_valid;
    logic                           w_out_ok;
    logic [skvt_pkg::VAL_W-1:0]     w_out_found;
    logic [skvt_pkg::CNT_W-1:0]     w_out_count;

    skvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    skvt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_op        (i_req.operation),
        .i_key       ({i_req.key_first, i_req.key_second}),
        .i_val       ({i_req.value_first, i_req.value_second}),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (w_out_valid),
        .o_out_ok    (w_out_ok),
        .o_out_found (w_out_found),
        .o_out_count (w_out_count)
    );

    // Channel hookup
    assign i_req.ready        = w_in_ready;
    assign o_rsp.valid        = w_out_valid;
    assign o_rsp.success      = w_out_ok;
    assign o_rsp.found_first  = w_out_found[skvt_pkg::VAL_W-1:skvt_pkg::HALF_W];
    assign o_rsp.found_second = w_out_found[skvt_pkg::HALF_W-1:0];
    assign o_rsp.stored_count = w_out_count;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for small_key_value_table_top: directed and random add/remove/look-up traffic
// checked against an in-bench table model. Depends on skvt_pkg and the skvt_if interfaces.

module testbench;
    import skvt_pkg::*;

    // Operation code that the block leaves unhandled
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;
    localparam int POOL_KEYS = 20;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [HALF_W-1:0] key_first;
        logic [HALF_W-1:0] key_second;
        logic [HALF_W-1:0] value_first;
        logic [HALF_W-1:0] value_second;
    } table_op_t;

    typedef struct packed {
        logic              success;
        logic [HALF_W-1:0] found_first;
        logic [HALF_W-1:0] found_second;
        logic [CNT_W-1:0]  stored_count;
    } table_result_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    skvt_req_if req_ch ();
    skvt_rsp_if rsp_ch ();

    small_key_value_table_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // Table model state
    logic [KEY_W-1:0] kv_keys [TABLE_SLOTS];
    logic [VAL_W-1:0] kv_vals [TABLE_SLOTS];
    logic             kv_used [TABLE_SLOTS];
    logic [CNT_W-1:0] kv_count;
    logic [CFG_W-1:0] kv_size;

    table_result_t pending_replies [$];
    logic [KEY_W-1:0] key_pool [POOL_KEYS];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int n_errors      = 0;
    int n_replies     = 0;
    int n_add = 0, n_remove = 0, n_lookup = 0, n_other = 0;
    int n_ok = 0, n_full = 0, n_size_writes = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        if (n_errors < MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        n_errors++;
    endtask

    // Model of one transaction: updates the table and returns the reply
    function automatic table_result_t apply_table_op(input table_op_t t);
        table_result_t    r;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        int               lim;
        int               hit;
        logic             done;
        r    = '0;
        key  = {t.key_first, t.key_second};
        val  = {t.value_first, t.value_second};
        lim  = kv_size;
        if (lim > TABLE_SLOTS) lim = TABLE_SLOTS;
        if (lim == 0) lim = 1;
        hit  = -1;
        done = 1'b0;
        // only live slots below the limit can match
        for (int i = 0; i < lim; i++)
            if (hit < 0 && kv_used[i] && kv_keys[i] == key) hit = i;
        case (t.op)
            OP_ADD: begin
                n_add++;
                if (hit >= 0) begin
                    kv_vals[hit] = val;
                    r.success = 1'b1;
                end else begin
                    for (int i = 0; i < lim; i++) begin
                        if (!done && !kv_used[i]) begin
                            kv_keys[i] = key;
                            kv_vals[i] = val;
                            kv_used[i] = 1'b1;
                            kv_count   = kv_count + 1'b1;
                            r.success  = 1'b1;
                            done       = 1'b1;
                        end
                    end
                    if (!done) n_full++;
                end
            end
            OP_REMOVE: begin
                n_remove++;
                if (hit >= 0) begin
                    {r.found_first, r.found_second} = kv_vals[hit];
                    r.success    = 1'b1;
                    kv_used[hit] = 1'b0;
                    kv_count     = kv_count - 1'b1;
                    // close the hole with the last entry of the run above it
                    for (int j = hit + 1; j < lim; j++) begin
                        if (!done && !kv_used[j]) begin
                            done = 1'b1;
                            if (j != hit + 1) begin
                                kv_keys[hit]   = kv_keys[j-1];
                                kv_vals[hit]   = kv_vals[j-1];
                                kv_used[hit]   = 1'b1;
                                kv_used[j-1]   = 1'b0;
                                kv_keys[j-1]   = '0;
                                kv_vals[j-1]   = '0;
                            end
                        end
                    end
                end
            end
            OP_LOOKUP: begin
                n_lookup++;
                if (hit >= 0) begin
                    {r.found_first, r.found_second} = kv_vals[hit];
                    r.success = 1'b1;
                end
            end
            default: n_other++;
        endcase
        r.stored_count = kv_count;
        if (r.success) n_ok++;
        return r;
    endfunction

    function automatic table_op_t make_op(input logic [OP_W-1:0] op,
                                          input logic [HALF_W-1:0] kf, input logic [HALF_W-1:0] ks,
                                          input logic [HALF_W-1:0] vf, input logic [HALF_W-1:0] vs);
        table_op_t t;
        t.op = op;
        t.key_first = kf;
        t.key_second = ks;
        t.value_first = vf;
        t.value_second = vs;
        return t;
    endfunction

    // Mostly keys from a small pool so that hits, fills and repairs happen
    function automatic table_op_t random_op(input int pool_n);
        table_op_t        t;
        int               r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 40)      t.op = OP_ADD;
        else if (r < 70) t.op = OP_REMOVE;
        else if (r < 95) t.op = OP_LOOKUP;
        else             t.op = OP_NOP;
        if ($urandom_range(0, 15) == 0) k = {$urandom, $urandom};
        else                            k = key_pool[$urandom_range(0, pool_n - 1)];
        t.key_first    = k[KEY_W-1:HALF_W];
        t.key_second   = k[HALF_W-1:0];
        t.value_first  = $urandom;
        t.value_second = $urandom;
        return t;
    endfunction

    // Send one transaction, with a random idle gap in front of it
    task automatic send_op(input table_op_t t);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= t.op;
        req_ch.key_first    <= t.key_first;
        req_ch.key_second   <= t.key_second;
        req_ch.value_first  <= t.value_first;
        req_ch.value_second <= t.value_second;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        pending_replies.push_back(apply_table_op(t));
    endtask

    // Stop sending until every outstanding reply is back
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_table_size(input logic [CFG_W-1:0] sz);
        hold_until_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= sz;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        kv_size     = sz;
        n_size_writes++;
    endtask

    // Reply checker; also drives the response-side stall pattern
    always @(posedge i_clk) begin : reply_check
        table_result_t want;
        rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            n_replies++;
            if (pending_replies.size() == 0) begin
                flag_mismatch($sformatf("reply %0d with no transaction outstanding", n_replies));
            end else begin
                want = pending_replies.pop_front();
                if (rsp_ch.success !== want.success)
                    flag_mismatch($sformatf("reply %0d success: got %b want %b",
                                            n_replies, rsp_ch.success, want.success));
                if (rsp_ch.found_first !== want.found_first)
                    flag_mismatch($sformatf("reply %0d found_first: got %h want %h",
                                            n_replies, rsp_ch.found_first, want.found_first));
                if (rsp_ch.found_second !== want.found_second)
                    flag_mismatch($sformatf("reply %0d found_second: got %h want %h",
                                            n_replies, rsp_ch.found_second, want.found_second));
                if (rsp_ch.stored_count !== want.stored_count)
                    flag_mismatch($sformatf("reply %0d stored_count: got %0d want %0d",
                                            n_replies, rsp_ch.stored_count, want.stored_count));
            end
        end
    end

    // Field extremes, every operation and the remove repair cases on an empty table
    task automatic test_basic_ops();
        send_op(make_op(OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0));     // empty slots never match
        send_op(make_op(OP_NOP, $urandom, $urandom, $urandom, $urandom));
        send_op(make_op(OP_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0));
        send_op(make_op(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        send_op(make_op(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0));
        send_op(make_op(OP_ADD, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF));
        send_op(make_op(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_op(make_op(OP_ADD, 32'h0, 32'h0, 32'h1234_5678, 32'h9ABC_DEF0)); // update
        send_op(make_op(OP_LOOKUP, 32'h0, 32'h0, $urandom, $urandom));
        // slot 0 freed, run of three above: last one moves down
        send_op(make_op(OP_REMOVE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
        send_op(make_op(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0));
        send_op(make_op(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0));
        // next slot already free: nothing moves
        send_op(make_op(OP_REMOVE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0));
        send_op(make_op(OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0));
        send_op(make_op(OP_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0));
    endtask

    // Full table, remove with no free slot below the limit, limit of zero
    task automatic test_full_and_limits();
        set_table_size(5'd3);
        send_op(make_op(OP_ADD, 32'h1, 32'h1, 32'hA, 32'hA));
        send_op(make_op(OP_ADD, 32'h2, 32'h2, 32'hB, 32'hB));
        send_op(make_op(OP_ADD, 32'h3, 32'h3, 32'hC, 32'hC));
        send_op(make_op(OP_ADD, 32'h4, 32'h4, 32'hD, 32'hD));   // refused, full
        send_op(make_op(OP_ADD, 32'h2, 32'h2, 32'hE, 32'hE));   // update while full
        send_op(make_op(OP_REMOVE, 32'h1, 32'h1, 32'h0, 32'h0));
        send_op(make_op(OP_ADD, 32'h4, 32'h4, 32'hD, 32'hD));
        set_table_size(5'd0);                                    // behaves as one slot
        send_op(make_op(OP_ADD, 32'h5, 32'h5, 32'hF, 32'hF));
        send_op(make_op(OP_LOOKUP, 32'h3, 32'h3, 32'h0, 32'h0)); // above the limit
        send_op(make_op(OP_LOOKUP, 32'h4, 32'h4, 32'h0, 32'h0));
        send_op(make_op(OP_REMOVE, 32'h4, 32'h4, 32'h0, 32'h0));
        send_op(make_op(OP_ADD, 32'h5, 32'h5, 32'hF, 32'hF));
    endtask

    // Random traffic over several table sizes and idle/stall patterns
    task automatic test_random_traffic();
        int sizes   [10] = '{16, 16, 31, 8, 1, 5, 17, 4, 0, 16};
        int s_idle  [10] = '{ 0, 64,  0, 7, 0, 64, 0, 7, 0,  7};
        int r_stall [10] = '{ 0,  0, 64, 7, 0, 0, 64, 7, 0,  7};
        int counts  [10] = '{200, 150, 150, 150, 60, 140, 150, 140, 60, 220};
        int active;
        int pool_n;
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = {32'h8000_0000, 32'h7FFF_FFFF};
        key_pool[3] = {32'h7FFF_FFFF, 32'h8000_0000};
        for (int i = 4; i < POOL_KEYS; i++) key_pool[i] = {$urandom, $urandom};
        for (int p = 0; p < 10; p++) begin
            set_table_size(sizes[p][CFG_W-1:0]);
            send_idle_pct = s_idle[p];
            stall_pct     = r_stall[p];
            active = (sizes[p] > TABLE_SLOTS) ? TABLE_SLOTS : ((sizes[p] == 0) ? 1 : sizes[p]);
            pool_n = (active + 4 > POOL_KEYS) ? POOL_KEYS : active + 4;
            for (int k = 0; k < counts[p]; k++) begin
                if ($urandom_range(0, 39) == 0) hold_until_drained();
                send_op(random_op(pool_n));
            end
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_data          <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.operation    <= OP_ADD;
        req_ch.key_first    <= '0;
        req_ch.key_second   <= '0;
        req_ch.value_first  <= '0;
        req_ch.value_second <= '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            kv_keys[i] = '0;
            kv_vals[i] = '0;
            kv_used[i] = 1'b0;
        end
        kv_count = '0;
        kv_size  = CFG_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_full_and_limits();
        test_random_traffic();

        // drain, then let the slowest remove finish
        hold_until_drained();
        repeat (2 * TABLE_SLOTS + 8) @(posedge i_clk);

        $display("Ran %0d transactions: %0d adds, %0d removes, %0d look-ups, %0d no-op codes.",
                 n_add + n_remove + n_lookup + n_other, n_add, n_remove, n_lookup, n_other);
        $display("%0d succeeded, %0d adds refused on a full table, %0d table-size writes.",
                 n_ok, n_full, n_size_writes);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
